>>> hdl/pfe_pkg.sv
// Package for the palette fade engine: command and result beat types, opcode,
// status and sequencer state codes, and the channel blend and RGB565 helpers.
// No dependencies.
package pfe_pkg;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_BLEND = 2'd2,
    OP_TINT  = 2'd3
  } pfe_op_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_BADPAL = 2'd1,
    ST_EMPTY  = 2'd2
  } pfe_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_READ,
    S_WAIT,
    S_RUN,
    S_FLUSH,
    S_REPORT
  } pfe_state_t;

  typedef struct packed {
    pfe_op_t     opcode;
    logic [7:0]  dest_palette;
    logic [7:0]  source_a;
    logic [7:0]  source_b;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [15:0] blend_amount;
    logic [8:0]  first_index;
    logic [8:0]  end_index;
  } pfe_cmd_t;

  typedef struct packed {
    pfe_status_t status;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [15:0] packed_out;
    logic [2:0]  active_palette;
  } pfe_result_t;

  localparam logic [7:0] AMT_MAX = 8'hFF;

  // One channel: (wb*amt + (255-amt)*wa) >> 8; the sum never exceeds 255*255
  function automatic logic [7:0] mix8(input logic [7:0] wb, input logic [7:0] wa,
                                      input logic [7:0] amt);
    logic [15:0] sum;
    sum = {8'd0, wb} * {8'd0, amt} + {8'd0, wa} * {8'd0, AMT_MAX - amt};
    return sum[15:8];
  endfunction

  // Blend all three channels of two RGB888 words
  function automatic logic [23:0] blend_rgb(input logic [23:0] wb, input logic [23:0] wa,
                                            input logic [7:0] amt);
    return {mix8(wb[23:16], wa[23:16], amt),
            mix8(wb[15:8], wa[15:8], amt),
            mix8(wb[7:0], wa[7:0], amt)};
  endfunction

  // RGB565 with red in the top bits
  function automatic logic [15:0] pack565(input logic [23:0] rgb);
    return {rgb[23:19], rgb[15:10], rgb[7:3]};
  endfunction

endpackage

>>> hdl/palette_fade_engine_core.sv
// Top level of the palette fade engine: command decode, blend sequencer and result
// register around the colour store. Depends on pfe_pkg and pfe_store.
//
//   channel  ports                  handshake
//   command  in_cmd, start, busy    beat taken when start is high and busy is low
//   result   out_result, out_valid  beat shown for one cycle, taken at its end
//
// Write holds busy in S_WRITE, read in S_READ then S_WAIT, a rejected command in
// S_REPORT. A blend holds busy through S_RUN, one read-modify-write of the store per
// entry at one entry per cycle, then S_FLUSH to retire the last write. The
// result beat follows the last busy cycle; the receiver cannot stall it. Reset clears
// the sequencer and the active palette; store contents stay undefined until written.
module palette_fade_engine_core #(
  parameter int PALETTES = 8,
  parameter int COLOURS  = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  pfe_pkg::pfe_cmd_t    in_cmd,
  output logic                out_valid,
  output pfe_pkg::pfe_result_t out_result
);
  import pfe_pkg::*;

  localparam int DEPTH  = PALETTES * COLOURS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = $clog2(COLOURS);
  localparam int PAL_W  = (PALETTES > 1) ? $clog2(PALETTES) : 1;
  localparam logic [8:0] PAL_LIM = 9'(PALETTES);
  localparam logic [8:0] COL_LIM = 9'(COLOURS);

  pfe_state_t        state_r, state_nxt;
  pfe_cmd_t          cmd_r, cmd_nxt;
  pfe_status_t       status_r, status_nxt;
  logic [7:0]        amt_r, amt_nxt;
  logic [ADDR_W-1:0] base_a_r, base_a_nxt;
  logic [ADDR_W-1:0] base_b_r, base_b_nxt;
  logic [ADDR_W-1:0] base_d_r, base_d_nxt;
  logic [IDX_W-1:0]  cur_r, cur_nxt;
  logic [IDX_W-1:0]  last_r, last_nxt;
  logic [PAL_W-1:0]  active_r, active_nxt;
  logic              p1_valid_r, p1_valid_nxt;
  logic [ADDR_W-1:0] p1_addr_r, p1_addr_nxt;
  logic              out_valid_r, out_valid_nxt;
  pfe_result_t       out_res_r, out_res_nxt;

  logic              accept;
  logic              dp_ok, sa_ok, sb_ok, idx_ok, range_ok;
  logic [8:0]        end_c;
  logic [ADDR_W-1:0] base_dp, base_sa, base_sb;
  logic [ADDR_W-1:0] issue_dst;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [23:0]       wr_true;
  logic [15:0]       wr_packed;
  logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
  logic [23:0]       rd_true_a, rd_true_b;
  logic [15:0]       rd_packed_a;
  logic [23:0]       mix_wb, blended;

  assign busy       = (state_r != S_IDLE);
  assign accept     = start && !busy;
  assign out_valid  = out_valid_r;
  assign out_result = out_res_r;

  // Decode checks on the incoming beat
  assign dp_ok    = {1'b0, in_cmd.dest_palette} < PAL_LIM;
  assign sa_ok    = {1'b0, in_cmd.source_a} < PAL_LIM;
  assign sb_ok    = {1'b0, in_cmd.source_b} < PAL_LIM;
  assign idx_ok   = in_cmd.first_index < COL_LIM;
  assign end_c    = (in_cmd.end_index > COL_LIM) ? COL_LIM : in_cmd.end_index;
  assign range_ok = in_cmd.first_index < end_c;
  assign base_dp  = ADDR_W'(32'(in_cmd.dest_palette) * 32'(COLOURS));
  assign base_sa  = ADDR_W'(32'(in_cmd.source_a) * 32'(COLOURS));
  assign base_sb  = ADDR_W'(32'(in_cmd.source_b) * 32'(COLOURS));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_cmd.opcode)
            OP_WRITE: state_nxt = (dp_ok && idx_ok) ? S_WRITE : S_REPORT;
            OP_READ:  state_nxt = (dp_ok && idx_ok) ? S_READ : S_REPORT;
            OP_BLEND: state_nxt = (dp_ok && sa_ok && sb_ok && range_ok) ? S_RUN : S_REPORT;
            OP_TINT:  state_nxt = (dp_ok && range_ok) ? S_RUN : S_REPORT;
            default:  state_nxt = S_REPORT;
          endcase
        end
      end
      S_WRITE:  state_nxt = S_IDLE;
      S_READ:   state_nxt = S_WAIT;
      S_WAIT:   state_nxt = S_IDLE;
      S_RUN:    state_nxt = (cur_r == last_r) ? S_FLUSH : S_RUN;
      S_FLUSH:  state_nxt = S_IDLE;
      S_REPORT: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Latch the command, work out status, bases and walk bounds, and step the walk
  always_comb begin
    cmd_nxt    = cmd_r;
    status_nxt = status_r;
    amt_nxt    = amt_r;
    base_a_nxt = base_a_r;
    base_b_nxt = base_b_r;
    base_d_nxt = base_d_r;
    cur_nxt    = cur_r;
    last_nxt   = last_r;
    active_nxt = active_r;
    if (accept) begin
      cmd_nxt    = in_cmd;
      amt_nxt    = (|in_cmd.blend_amount[15:8]) ? AMT_MAX : in_cmd.blend_amount[7:0];
      base_d_nxt = base_dp;
      base_a_nxt = (in_cmd.opcode == OP_BLEND) ? base_sa : base_dp;
      base_b_nxt = (in_cmd.opcode == OP_BLEND) ? base_sb : base_dp;
      cur_nxt    = IDX_W'(in_cmd.first_index);
      last_nxt   = IDX_W'(end_c - 9'd1);
      unique case (in_cmd.opcode)
        OP_WRITE, OP_READ: begin
          priority if (!dp_ok) status_nxt = ST_BADPAL;
          else if (!idx_ok)    status_nxt = ST_EMPTY;
          else                 status_nxt = ST_DONE;
        end
        OP_BLEND: begin
          priority if (!(dp_ok && sa_ok && sb_ok)) status_nxt = ST_BADPAL;
          else if (!range_ok)                      status_nxt = ST_EMPTY;
          else                                     status_nxt = ST_DONE;
        end
        OP_TINT: begin
          priority if (!dp_ok) status_nxt = ST_BADPAL;
          else if (!range_ok)  status_nxt = ST_EMPTY;
          else                 status_nxt = ST_DONE;
          // The palette turns active even over an empty range
          if (dp_ok) active_nxt = PAL_W'(in_cmd.dest_palette);
        end
        default: status_nxt = ST_BADPAL;
      endcase
    end else if (state_r == S_RUN && cur_r != last_r) begin
      cur_nxt = cur_r + 1'b1;
    end
  end

  // Store addressing: issue a read per entry, write it back in the following cycle
  assign rd_addr_a    = base_a_r + ADDR_W'(cur_r);
  assign rd_addr_b    = base_b_r + ADDR_W'(cur_r);
  assign issue_dst    = base_d_r + ADDR_W'(cur_r);
  assign p1_valid_nxt = (state_r == S_RUN);
  assign p1_addr_nxt  = issue_dst;

  assign mix_wb    = (cmd_r.opcode == OP_BLEND) ? rd_true_b
                                                : {cmd_r.red_in, cmd_r.green_in, cmd_r.blue_in};
  assign blended   = blend_rgb(mix_wb, rd_true_a, amt_r);
  assign wr_en     = (state_r == S_WRITE) || p1_valid_r;
  assign wr_addr   = p1_valid_r ? p1_addr_r : issue_dst;
  assign wr_true   = p1_valid_r ? blended : {cmd_r.red_in, cmd_r.green_in, cmd_r.blue_in};
  assign wr_packed = pack565(wr_true);

  // Result beat
  always_comb begin
    out_valid_nxt = (state_r == S_WRITE) || (state_r == S_WAIT) ||
                    (state_r == S_FLUSH) || (state_r == S_REPORT);
    out_res_nxt                = '0;
    out_res_nxt.status         = status_r;
    out_res_nxt.active_palette = 3'(active_r);
    if (state_r == S_WAIT) begin
      out_res_nxt.red_out    = rd_true_a[23:16];
      out_res_nxt.green_out  = rd_true_a[15:8];
      out_res_nxt.blue_out   = rd_true_a[7:0];
      out_res_nxt.packed_out = rd_packed_a;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= '0;
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      p1_valid_r  <= p1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    status_r  <= status_nxt;
    amt_r     <= amt_nxt;
    base_a_r  <= base_a_nxt;
    base_b_r  <= base_b_nxt;
    base_d_r  <= base_d_nxt;
    cur_r     <= cur_nxt;
    last_r    <= last_nxt;
    p1_addr_r <= p1_addr_nxt;
    out_res_r <= out_res_nxt;
  end

  pfe_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk         (clk),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_true     (wr_true),
    .wr_packed   (wr_packed),
    .rd_addr_a   (rd_addr_a),
    .rd_addr_b   (rd_addr_b),
    .rd_true_a   (rd_true_a),
    .rd_true_b   (rd_true_b),
    .rd_packed_a (rd_packed_a)
  );

  // Write-back stage only runs while a blend walks or retires its last entry
  a_wb_in_blend: assert property (@(posedge clk) disable iff (!rst_n)
    p1_valid_r |-> (state_r == S_RUN || state_r == S_FLUSH))
    else $error("write-back outside a blend");

  // Every accepted beat leaves idle
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != S_IDLE))
    else $error("accepted beat left the sequencer idle");

  // The walk never passes its last entry
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (cur_r <= last_r))
    else $error("blend index passed range end");

  // A result beat only follows a busy cycle
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(busy))
    else $error("result beat without a command");

endmodule

>>> hdl/pfe_store.sv
// Colour store of the palette fade engine: RGB888 array with two read ports and
// the RGB565 copy with one, sharing a single write port. Reads are registered.
// No package dependencies.
module pfe_store #(
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = 11
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [23:0]       wr_true,
  input  logic [15:0]       wr_packed,
  input  logic [ADDR_W-1:0] rd_addr_a,
  input  logic [ADDR_W-1:0] rd_addr_b,
  output logic [23:0]       rd_true_a,
  output logic [23:0]       rd_true_b,
  output logic [15:0]       rd_packed_a
);

  logic [23:0] true_mem   [DEPTH];
  logic [15:0] packed_mem [DEPTH];

  // Write both copies of an entry together
  always_ff @(posedge clk) begin
    if (wr_en) begin
      true_mem[wr_addr]   <= wr_true;
      packed_mem[wr_addr] <= wr_packed;
    end
  end

  // Registered reads
  always_ff @(posedge clk) begin
    rd_true_a   <= true_mem[rd_addr_a];
    rd_true_b   <= true_mem[rd_addr_b];
    rd_packed_a <= packed_mem[rd_addr_a];
  end

endmodule

>>> tb/sv/tb_top.sv
// Self-checking bench for palette_fade_engine_core: directed and random commands
// checked beat by beat against a scoreboard that tracks both colour stores.
// Depends on pfe_pkg and the core RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pfe_pkg::*;

  localparam int NUM_PAL     = 8;
  localparam int NUM_COL     = 256;
  localparam int ITEM_TARGET = 1950;
  localparam int STALL_LIMIT = 5000;

  // Palette state mirror and queue of results still owed by the core
  class pfe_scoreboard;
    logic [23:0]  rgb_mem    [NUM_PAL*NUM_COL];
    logic [15:0]  rgb565_mem [NUM_PAL*NUM_COL];
    logic [2:0]   active;
    pfe_result_t  owed_q[$];
    int           errors;

    function new();
      active = '0;
      errors = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function logic [7:0] mix_channel(logic [7:0] wb, logic [7:0] wa, logic [7:0] amt);
      int s;
      s = int'(wb) * int'(amt) + (255 - int'(amt)) * int'(wa);
      return 8'(s >> 8);
    endfunction

    function logic [23:0] blend_colour(logic [23:0] wb, logic [23:0] wa, logic [7:0] amt);
      return {mix_channel(wb[23:16], wa[23:16], amt),
              mix_channel(wb[15:8], wa[15:8], amt),
              mix_channel(wb[7:0], wa[7:0], amt)};
    endfunction

    function void put_colour(int slot, logic [23:0] rgb);
      rgb_mem[slot]    = rgb;
      rgb565_mem[slot] = {rgb[23:19], rgb[15:10], rgb[7:3]};
    endfunction

    // Apply one accepted command to the mirror and queue the result it owes
    function void note_command(pfe_cmd_t c);
      pfe_result_t r;
      logic [7:0]  amt;
      int          lo, hi, slot, i, dp, sa, sb;
      r        = '0;
      r.status = ST_DONE;
      amt      = (c.blend_amount > 16'd255) ? 8'hFF : c.blend_amount[7:0];
      lo       = int'(c.first_index);
      hi       = (int'(c.end_index) > NUM_COL) ? NUM_COL : int'(c.end_index);
      dp       = int'(c.dest_palette);
      sa       = int'(c.source_a);
      sb       = int'(c.source_b);
      case (c.opcode)
        OP_WRITE, OP_READ: begin
          if (dp >= NUM_PAL) begin
            r.status = ST_BADPAL;
          end else if (lo >= NUM_COL) begin
            r.status = ST_EMPTY;
          end else begin
            slot = dp * NUM_COL + lo;
            if (c.opcode == OP_WRITE) begin
              put_colour(slot, {c.red_in, c.green_in, c.blue_in});
            end else begin
              r.red_out    = rgb_mem[slot][23:16];
              r.green_out  = rgb_mem[slot][15:8];
              r.blue_out   = rgb_mem[slot][7:0];
              r.packed_out = rgb565_mem[slot];
            end
          end
        end
        OP_BLEND: begin
          if (dp >= NUM_PAL || sa >= NUM_PAL || sb >= NUM_PAL) begin
            r.status = ST_BADPAL;
          end else if (lo >= hi) begin
            r.status = ST_EMPTY;
          end else begin
            // each entry is read before it is written, so aliasing is harmless
            for (i = lo; i < hi; i++)
              put_colour(dp * NUM_COL + i, blend_colour(rgb_mem[sb * NUM_COL + i],
                                                        rgb_mem[sa * NUM_COL + i], amt));
          end
        end
        default: begin
          if (dp >= NUM_PAL) begin
            r.status = ST_BADPAL;
          end else begin
            // an empty range still switches the active palette
            active = 3'(dp);
            if (lo >= hi) begin
              r.status = ST_EMPTY;
            end else begin
              for (i = lo; i < hi; i++) begin
                slot = dp * NUM_COL + i;
                put_colour(slot, blend_colour({c.red_in, c.green_in, c.blue_in},
                                              rgb_mem[slot], amt));
              end
            end
          end
        end
      endcase
      r.active_palette = active;
      owed_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    // Match a result beat against the oldest owed result
    function void check_result(pfe_result_t got);
      pfe_result_t want;
      if (owed_q.size() == 0) begin
        $error("result beat with nothing outstanding: 0x%0h", got);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      compare_field("status", 16'(want.status), 16'(got.status));
      compare_field("red_out", 16'(want.red_out), 16'(got.red_out));
      compare_field("green_out", 16'(want.green_out), 16'(got.green_out));
      compare_field("blue_out", 16'(want.blue_out), 16'(got.blue_out));
      compare_field("packed_out", want.packed_out, got.packed_out);
      compare_field("active_palette", 16'(want.active_palette), 16'(got.active_palette));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  pfe_cmd_t    in_cmd;
  logic        out_valid;
  pfe_result_t out_result;

  pfe_scoreboard sb;
  bit            filled [NUM_PAL][NUM_COL];
  int            items_sent;
  bit            gap_on;
  int            idle_cycles;

  palette_fade_engine_core #(
    .PALETTES(NUM_PAL),
    .COLOURS (NUM_COL)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_cmd    (in_cmd),
    .out_valid (out_valid),
    .out_result(out_result)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Take every result beat at the edge that ends it
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_result);
  end

  // Abort when neither channel moves a beat for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic pfe_cmd_t make_cmd(pfe_op_t op, int dp, int sa, int sb_pal,
                                        logic [23:0] rgb, int amt, int first, int stop_at);
    pfe_cmd_t c;
    c.opcode       = op;
    c.dest_palette = 8'(dp);
    c.source_a     = 8'(sa);
    c.source_b     = 8'(sb_pal);
    c.red_in       = rgb[23:16];
    c.green_in     = rgb[15:8];
    c.blue_in      = rgb[7:0];
    c.blend_amount = 16'(amt);
    c.first_index  = 9'(first);
    c.end_index    = 9'(stop_at);
    return c;
  endfunction

  function automatic pfe_cmd_t random_fields();
    return make_cmd(pfe_op_t'($urandom_range(0, 3)), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 255), 24'($urandom),
                    $urandom_range(0, 65535), $urandom_range(0, 256), $urandom_range(0, 256));
  endfunction

  function automatic int pick_amount();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 255;
      2: return $urandom_range(0, 255);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // Length of the run from 'from' over which both palettes hold written entries
  function automatic int written_run(int pa, int pb, int from);
    int n = 0;
    while (from + n < NUM_COL && filled[pa][from + n] && filled[pb][from + n]) n++;
    return n;
  endfunction

  // Drive one command beat, wait for it to be taken, then idle a while
  task automatic issue(input pfe_cmd_t c);
    int gap, i;
    gap = gap_on ? $urandom_range(0, 10) : 0;
    if (c.dest_palette < NUM_PAL) begin
      if (c.opcode == OP_WRITE && c.first_index < NUM_COL)
        filled[c.dest_palette][c.first_index] = 1'b1;
      if (c.opcode == OP_BLEND && c.source_a < NUM_PAL && c.source_b < NUM_PAL)
        for (i = c.first_index; i < c.end_index && i < NUM_COL; i++)
          filled[c.dest_palette][i] = 1'b1;
    end
    @(negedge clk);
    start  <= 1'b1;
    in_cmd <= c;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_command(c);
    items_sent++;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Hold off new commands until every owed result has come back
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    pfe_cmd_t c;
    int       kind, pal, idx, len, run, k, tries, pa, pb, next_pause;
    bit       found;

    sb         = new();
    rst_n      = 1'b0;
    start      = 1'b0;
    in_cmd     = '0;
    items_sent = 0;
    gap_on     = 1'b1;
    next_pause = 400;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, every opcode and each error path
    issue(make_cmd(OP_WRITE, 0, 0, 0, 24'h000000, 0, 0, 0));
    issue(make_cmd(OP_WRITE, 0, 0, 0, 24'hFFFFFF, 16'hFFFF, 255, 0));
    issue(make_cmd(OP_WRITE, 7, 0, 0, 24'hA55AFF, 0, 0, 0));
    issue(make_cmd(OP_WRITE, 7, 0, 0, 24'h5AA500, 0, 255, 0));
    issue(make_cmd(OP_READ, 0, 0, 0, 24'h0, 0, 0, 0));
    issue(make_cmd(OP_READ, 0, 0, 0, 24'h0, 0, 255, 0));
    issue(make_cmd(OP_READ, 7, 0, 0, 24'h0, 0, 255, 0));
    // palette numbers just past and far past the last one
    issue(make_cmd(OP_WRITE, 8, 0, 0, 24'h123456, 0, 1, 0));
    issue(make_cmd(OP_READ, 255, 0, 0, 24'h0, 0, 0, 0));
    // entry index past the end of a palette
    issue(make_cmd(OP_WRITE, 3, 0, 0, 24'h808080, 0, 256, 0));
    issue(make_cmd(OP_READ, 0, 0, 0, 24'h0, 0, 256, 0));
    // zero, saturated and just-over-range amounts
    issue(make_cmd(OP_BLEND, 1, 0, 7, 24'h0, 0, 0, 1));
    issue(make_cmd(OP_BLEND, 1, 0, 7, 24'h0, 16'hFFFF, 255, 256));
    issue(make_cmd(OP_BLEND, 2, 0, 7, 24'h0, 16'h0100, 255, 256));
    issue(make_cmd(OP_BLEND, 1, 8, 0, 24'h0, 128, 0, 1));
    issue(make_cmd(OP_BLEND, 1, 0, 200, 24'h0, 128, 0, 1));
    // empty ranges, including a start beyond the end
    issue(make_cmd(OP_BLEND, 1, 0, 7, 24'h0, 128, 5, 5));
    issue(make_cmd(OP_BLEND, 1, 0, 7, 24'h0, 128, 256, 0));
    issue(make_cmd(OP_TINT, 1, 0, 0, 24'hFF8000, 128, 0, 1));
    issue(make_cmd(OP_TINT, 7, 0, 0, 24'h00FF00, 200, 3, 2));
    issue(make_cmd(OP_TINT, 9, 0, 0, 24'h0000FF, 50, 0, 1));
    // sources aliasing the destination
    issue(make_cmd(OP_BLEND, 0, 0, 0, 24'h0, 77, 255, 256));
    issue(make_cmd(OP_READ, 1, 0, 0, 24'h0, 0, 0, 0));
    issue(make_cmd(OP_READ, 1, 0, 0, 24'h0, 0, 255, 0));
    issue(make_cmd(OP_READ, 0, 0, 0, 24'h0, 0, 255, 0));
    wait_drained();

    // Random: mostly legal traffic over written entries, some malformed commands
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 49) == 0) gap_on = !gap_on;
      if (items_sent >= next_pause) begin
        wait_drained();
        next_pause += 400;
      end
      kind = $urandom_range(0, 99);
      c    = random_fields();
      if (kind < 25) begin
        // burst of writes along one palette, now and then a whole palette
        pal = $urandom_range(0, NUM_PAL - 1);
        idx = $urandom_range(0, NUM_COL - 1);
        len = $urandom_range(1, 16);
        if ($urandom_range(0, 63) == 0) begin
          idx = 0;
          len = NUM_COL;
        end
        for (k = 0; k < len && idx + k < NUM_COL; k++) begin
          c              = random_fields();
          c.opcode       = OP_WRITE;
          c.dest_palette = 8'(pal);
          c.first_index  = 9'(idx + k);
          issue(c);
        end
      end else if (kind < 45) begin
        // read back an entry that holds data
        pal   = $urandom_range(0, NUM_PAL - 1);
        found = 1'b0;
        for (tries = 0; tries < 16 && !found; tries++) begin
          idx   = $urandom_range(0, NUM_COL - 1);
          found = filled[pal][idx];
        end
        if (found) begin
          c.opcode       = OP_READ;
          c.dest_palette = 8'(pal);
          c.first_index  = 9'(idx);
          issue(c);
        end
      end else if (kind < 85) begin
        // blend or tint over a run of written entries
        c.opcode       = (kind < 70) ? OP_BLEND : OP_TINT;
        c.dest_palette = 8'($urandom_range(0, NUM_PAL - 1));
        c.source_a     = 8'($urandom_range(0, NUM_PAL - 1));
        c.source_b     = 8'($urandom_range(0, NUM_PAL - 1));
        pa  = (c.opcode == OP_BLEND) ? int'(c.source_a) : int'(c.dest_palette);
        pb  = (c.opcode == OP_BLEND) ? int'(c.source_b) : int'(c.dest_palette);
        run = 0;
        for (tries = 0; tries < 8 && run == 0; tries++) begin
          idx = (tries == 0) ? 0 : $urandom_range(0, NUM_COL - 1);
          run = written_run(pa, pb, idx);
        end
        if (run > 0) begin
          len            = ($urandom_range(0, 3) == 0) ? run : $urandom_range(1, run);
          c.first_index  = 9'(idx);
          c.end_index    = 9'(idx + len);
          c.blend_amount = 16'(pick_amount());
          issue(c);
        end
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            // bad palette number in one of the palette fields
            if (c.opcode == OP_BLEND) begin
              case ($urandom_range(0, 2))
                0: c.dest_palette = 8'($urandom_range(NUM_PAL, 255));
                1: c.source_a = 8'($urandom_range(NUM_PAL, 255));
                default: c.source_b = 8'($urandom_range(NUM_PAL, 255));
              endcase
            end else begin
              c.dest_palette = 8'($urandom_range(NUM_PAL, 255));
            end
          end
          1: begin
            // empty range on legal palettes
            c.opcode       = $urandom_range(0, 1) ? OP_BLEND : OP_TINT;
            c.dest_palette = 8'($urandom_range(0, NUM_PAL - 1));
            c.source_a     = 8'($urandom_range(0, NUM_PAL - 1));
            c.source_b     = 8'($urandom_range(0, NUM_PAL - 1));
            c.end_index    = 9'($urandom_range(0, 256));
            c.first_index  = 9'($urandom_range(c.end_index, 256));
          end
          default: begin
            // write or read past the last entry
            c.opcode       = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
            c.dest_palette = 8'($urandom_range(0, NUM_PAL - 1));
            c.first_index  = 9'(NUM_COL);
          end
        endcase
        issue(c);
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
